/* design/sawarq_pkg.sv */
package sawarq_pkg;

   // input opcodes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_ACK   = 2'd1;
   localparam logic [1:0] OP_START = 2'd2;

   // result kinds
   localparam logic KIND_FRAME  = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   // configuration register indexes
   localparam logic [1:0] REG_TIMEOUT      = 2'd0;
   localparam logic [1:0] REG_REPORT_EVERY = 2'd1;
   localparam logic [1:0] REG_SLOW_MODE    = 2'd2;
   localparam logic [1:0] REG_RETRY_LIMIT  = 2'd3;

   localparam logic [15:0] TIMEOUT_RESET      = 16'd100;
   localparam logic [15:0] REPORT_EVERY_RESET = 16'd100;
   localparam logic [3:0]  RETRY_LIMIT_RESET  = 4'd10;

   localparam logic [3:0]  SEND_COUNT_MAX = 4'hf;
   localparam logic [15:0] TIMER_MAX      = 16'hffff;
   localparam logic [31:0] ELAPSED_MAX    = 32'hffff_ffff;

   typedef struct packed {
      logic [15:0] timeout_ticks;
      logic [15:0] report_every;
      logic        slow_mode;
      logic [3:0]  retry_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] ack_seq_first;
      logic [15:0] ack_seq_second;
   } item_type;

   typedef struct packed {
      logic        result_kind;
      logic [15:0] frame_seq;
      logic [15:0] report_count;
      logic [31:0] report_ticks;
      logic        last;
   } result_type;

   // results of one processed word: count of 0, 1 or 2 and the results in order
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } step_type;

endpackage

/* design/sawarq_req_if.sv */
interface sawarq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [15:0] ack_seq_first;
   logic [15:0] ack_seq_second;

   modport source (output valid, output opcode, output ack_seq_first,
                   output ack_seq_second, input ready);
   modport sink (input valid, input opcode, input ack_seq_first,
                 input ack_seq_second, output ready);
endinterface

/* design/sawarq_rsp_if.sv */
interface sawarq_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [15:0] frame_seq;
   logic [15:0] report_count;
   logic [31:0] report_ticks;
   logic        last;

   modport source (output valid, output result_kind, output frame_seq,
                   output report_count, output report_ticks, output last,
                   input ready);
   modport sink (input valid, input result_kind, input frame_seq,
                 input report_count, input report_ticks, input last,
                 output ready);
endinterface

/* design/sawarq_core.sv */
module sawarq_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  sawarq_pkg::item_type item,
   input  sawarq_pkg::cfg_type  cfg,
   output sawarq_pkg::step_type step
);

   logic [15:0] seq_ff, seq_in;
   logic [3:0]  send_count_ff, send_count_in;
   logic [15:0] timer_ff, timer_in;
   logic        acked_ff, acked_in;
   logic        waiting_ff, waiting_in;
   logic [15:0] delivered_ff, delivered_in;
   logic [31:0] elapsed_ff, elapsed_in;

   logic                   end_wait;
   logic                   send;
   logic                   report;
   logic                   ack_ok;
   logic [15:0]            timer_inc;
   logic [15:0]            delivered_inc;
   sawarq_pkg::result_type frame_res;
   sawarq_pkg::result_type report_res;

   always_comb begin
      seq_in        = seq_ff;
      send_count_in = send_count_ff;
      timer_in      = timer_ff;
      acked_in      = acked_ff;
      waiting_in    = waiting_ff;
      delivered_in  = delivered_ff;
      elapsed_in    = elapsed_ff;
      end_wait      = 1'b0;
      send          = 1'b0;
      report        = 1'b0;

      ack_ok = (item.ack_seq_first == item.ack_seq_second)
               && (item.ack_seq_first == seq_ff);
      timer_inc = (timer_ff == sawarq_pkg::TIMER_MAX) ? timer_ff : timer_ff + 16'd1;
      delivered_inc = delivered_ff + 16'd1;

      case (item.opcode)
         sawarq_pkg::OP_TICK: begin
            if (elapsed_ff != sawarq_pkg::ELAPSED_MAX)
               elapsed_in = elapsed_ff + 32'd1;
            if (waiting_ff) begin
               timer_in = timer_inc;
               end_wait = (timer_inc >= cfg.timeout_ticks);
            end
         end
         sawarq_pkg::OP_ACK: begin
            if (ack_ok) begin
               acked_in     = 1'b1;
               delivered_in = delivered_inc;
               if (delivered_inc == cfg.report_every) begin
                  report       = 1'b1;
                  delivered_in = 16'd0;
               end
               end_wait = !cfg.slow_mode && waiting_ff;
            end
         end
         sawarq_pkg::OP_START: begin
            send = !waiting_ff;
         end
         default: begin
         end
      endcase

      // advance on ack or when retries are used up, else count a resend
      if (end_wait) begin
         send = 1'b1;
         if (acked_in || (send_count_ff >= cfg.retry_limit)) begin
            send_count_in = 4'd0;
            seq_in        = seq_ff + 16'd1;
         end else if (send_count_ff != sawarq_pkg::SEND_COUNT_MAX) begin
            send_count_in = send_count_ff + 4'd1;
         end
      end

      if (send) begin
         acked_in   = 1'b0;
         timer_in   = 16'd0;
         waiting_in = 1'b1;
         if (delivered_in == 16'd0)
            elapsed_in = 32'd0;
      end

      frame_res.result_kind  = sawarq_pkg::KIND_FRAME;
      frame_res.frame_seq    = seq_in;
      frame_res.report_count = 16'd0;
      frame_res.report_ticks = 32'd0;
      frame_res.last         = 1'b1;

      report_res.result_kind  = sawarq_pkg::KIND_REPORT;
      report_res.frame_seq    = 16'd0;
      report_res.report_count = cfg.report_every;
      report_res.report_ticks = elapsed_ff;
      report_res.last         = !send;

      step.count  = {1'b0, report} + {1'b0, send};
      step.first  = report ? report_res : frame_res;
      step.second = frame_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff        <= 16'd0;
         send_count_ff <= 4'd0;
         timer_ff      <= 16'd0;
         acked_ff      <= 1'b0;
         waiting_ff    <= 1'b0;
         delivered_ff  <= 16'd0;
         elapsed_ff    <= 32'd0;
      end else if (go) begin
         seq_ff        <= seq_in;
         send_count_ff <= send_count_in;
         timer_ff      <= timer_in;
         acked_ff      <= acked_in;
         waiting_ff    <= waiting_in;
         delivered_ff  <= delivered_in;
         elapsed_ff    <= elapsed_in;
      end
   end

endmodule

/* design/stop_and_wait_arq_sender.sv */
// channel | dir | handshake          | word
// --------+-----+--------------------+-------------------------------------------
// req     | in  | valid/ready        | opcode, ack_seq_first, ack_seq_second
// rsp     | out | valid/ready        | result_kind, frame_seq, report_count,
//         |     |                    | report_ticks, last
// csr     | in  | csr_we, no wait    | csr_index, csr_wdata
//
// A word is captured in the input register and, when the buffer can take it, is
// turned into up to two results that land in a two-entry output buffer at the
// next edge. A word yielding one result keeps one word per cycle while rsp is
// ready; a report followed by a frame holds the next word while the buffer drains.
// Reset is synchronous and returns state and configuration to their defaults.
// A stalled rsp holds the input register, which then holds off req.
module stop_and_wait_arq_sender (
   input  logic          clock,
   input  logic          reset,
   sawarq_req_if.sink    req,
   sawarq_rsp_if.source  rsp,
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [15:0]   csr_wdata
);

   sawarq_pkg::cfg_type    cfg_ff;
   logic                   in_valid_ff;
   sawarq_pkg::item_type   in_ff;
   sawarq_pkg::result_type slot_ff [2];
   logic [1:0]             count_ff, count_in;
   sawarq_pkg::step_type   step;

   logic go;
   logic pop;
   logic take;

   assign pop  = rsp.valid && rsp.ready;
   assign go   = in_valid_ff && ((count_ff == 2'd0) || ((count_ff == 2'd1) && pop));
   assign take = req.valid && req.ready;

   assign req.ready = !in_valid_ff || go;

   assign rsp.valid        = (count_ff != 2'd0);
   assign rsp.result_kind  = slot_ff[0].result_kind;
   assign rsp.frame_seq    = slot_ff[0].frame_seq;
   assign rsp.report_count = slot_ff[0].report_count;
   assign rsp.report_ticks = slot_ff[0].report_ticks;
   assign rsp.last         = slot_ff[0].last;

   sawarq_core u_core (
      .clock (clock),
      .reset (reset),
      .go    (go),
      .item  (in_ff),
      .cfg   (cfg_ff),
      .step  (step)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks <= sawarq_pkg::TIMEOUT_RESET;
         cfg_ff.report_every  <= sawarq_pkg::REPORT_EVERY_RESET;
         cfg_ff.slow_mode     <= 1'b0;
         cfg_ff.retry_limit   <= sawarq_pkg::RETRY_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            sawarq_pkg::REG_TIMEOUT:      cfg_ff.timeout_ticks <= csr_wdata;
            sawarq_pkg::REG_REPORT_EVERY: cfg_ff.report_every  <= csr_wdata;
            sawarq_pkg::REG_SLOW_MODE:    cfg_ff.slow_mode     <= csr_wdata[0];
            sawarq_pkg::REG_RETRY_LIMIT:  cfg_ff.retry_limit   <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take) begin
         in_valid_ff <= 1'b1;
      end else if (go) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_ff.opcode         <= req.opcode;
         in_ff.ack_seq_first  <= req.ack_seq_first;
         in_ff.ack_seq_second <= req.ack_seq_second;
      end
   end

   always_comb begin
      if (go)
         count_in = step.count;
      else
         count_in = count_ff - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   // buffer is empty after this edge whenever go is high, so overwrite both
   always_ff @(posedge clock) begin
      if (go) begin
         slot_ff[0] <= step.first;
         slot_ff[1] <= step.second;
      end else if (pop) begin
         slot_ff[0] <= slot_ff[1];
      end
   end

endmodule
